/* src/log_sector_deframer_assert.svh */
// assertion macros for the log sector deframer
`ifndef LOG_SECTOR_DEFRAMER_ASSERT_SVH
`define LOG_SECTOR_DEFRAMER_ASSERT_SVH

// clocked assertion, off during reset
`define LSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// clocked check on the cycle after the trigger, off during reset
`define LSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

/* src/lsd_pkg.sv */
// shared types and constants of the log sector deframer
package lsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 16;
  localparam int unsigned TrailW  = 4;

  localparam logic [TrailW-1:0] PreSumSkip  = TrailW'(10);
  localparam logic [TrailW-1:0] PostSumSkip = TrailW'(5);

  localparam logic [ByteW-1:0] CharE = 8'h45;
  localparam logic [ByteW-1:0] CharN = 8'h4E;
  localparam logic [ByteW-1:0] CharD = 8'h44;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_BYTE    = 2'd1,
    KIND_TIMEOUT = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD     = 2'd1,
    STATUS_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DATA = 4'b0010,
    PH_PRE  = 4'b0100,
    PH_POST = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0]       kind;
    logic [ByteW-1:0] rx_byte;
  } in_word_t;

  typedef struct packed {
    logic             data_valid;
    logic [ByteW-1:0] out_byte;
    logic             done_res;
    logic [1:0]       status;
    logic [LenW-1:0]  data_length;
  } res_word_t;

endpackage

/* src/lsd_core.sv */
// sector state and per-word deframing step
`include "log_sector_deframer_assert.svh"

module lsd_core import lsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  output logic      res_vld_o,
  output res_word_t res_o
);

  phase_e            phase_q, phase_d;
  logic [ByteW-1:0]  prev_q, prev_d;
  logic [ByteW-1:0]  prev2_q, prev2_d;
  logic [ByteW-1:0]  xor_q, xor_d;
  logic [LenW-1:0]   cnt_q, cnt_d;
  logic [TrailW-1:0] trail_q, trail_d;
  logic [ByteW-1:0]  rsum_q, rsum_d;
  logic [LenW-1:0]   data_len;
  logic [TrailW-1:0] trail_inc;

  assign data_len  = (cnt_q >= LenW'(2)) ? cnt_q - LenW'(2) : '0;
  assign trail_inc = trail_q + TrailW'(1);

  always_comb begin
    phase_d   = phase_q;
    prev_d    = prev_q;
    prev2_d   = prev2_q;
    xor_d     = xor_q;
    cnt_d     = cnt_q;
    trail_d   = trail_q;
    rsum_d    = rsum_q;
    res_vld_o = 1'b0;
    res_o     = '0;
    if (step_i) begin
      unique case (word_i.kind)
        KIND_START: begin
          phase_d = PH_DATA;
          prev_d  = '0;
          prev2_d = '0;
          xor_d   = '0;
          cnt_d   = '0;
          trail_d = '0;
          rsum_d  = '0;
        end
        KIND_TIMEOUT: begin
          if (phase_q != PH_IDLE) begin
            res_vld_o         = 1'b1;
            res_o.done_res    = 1'b1;
            res_o.status      = STATUS_TIMEOUT;
            res_o.data_length = data_len;
            phase_d           = PH_IDLE;
          end
        end
        KIND_BYTE: begin
          unique case (phase_q)
            PH_DATA: begin
              if (prev2_q == CharE && prev_q == CharN && word_i.rx_byte == CharD) begin
                xor_d   = xor_q ^ CharN ^ CharE;
                trail_d = '0;
                phase_d = PH_PRE;
              end else begin
                if (cnt_q >= LenW'(2)) begin
                  res_vld_o        = 1'b1;
                  res_o.data_valid = 1'b1;
                  res_o.out_byte   = prev2_q;
                end
                xor_d   = xor_q ^ word_i.rx_byte;
                prev2_d = prev_q;
                prev_d  = word_i.rx_byte;
                if (cnt_q != LenMax) begin
                  cnt_d = cnt_q + LenW'(1);
                end
              end
            end
            PH_PRE: begin
              if (trail_q < PreSumSkip) begin
                trail_d = trail_inc;
              end else begin
                rsum_d  = word_i.rx_byte;
                trail_d = '0;
                phase_d = PH_POST;
                if (PostSumSkip == '0) begin
                  res_vld_o         = 1'b1;
                  res_o.done_res    = 1'b1;
                  res_o.status      = (xor_q == word_i.rx_byte) ? STATUS_OK : STATUS_BAD;
                  res_o.data_length = data_len;
                  phase_d           = PH_IDLE;
                end
              end
            end
            PH_POST: begin
              trail_d = trail_inc;
              if (trail_inc >= PostSumSkip) begin
                res_vld_o         = 1'b1;
                res_o.done_res    = 1'b1;
                res_o.status      = (xor_q == rsum_q) ? STATUS_OK : STATUS_BAD;
                res_o.data_length = data_len;
                phase_d           = PH_IDLE;
              end
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= '0;
      prev2_q <= '0;
      xor_q   <= '0;
      cnt_q   <= '0;
      trail_q <= '0;
      rsum_q  <= '0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      prev2_q <= prev2_d;
      xor_q   <= xor_d;
      cnt_q   <= cnt_d;
      trail_q <= trail_d;
      rsum_q  <= rsum_d;
    end
  end

  `LSD_ASSERT(a_data_only_in_data,
              res_vld_o && res_o.data_valid |-> phase_q == PH_DATA,
              "data word outside data phase")
  `LSD_ASSERT_NEXT(a_done_to_idle,
                   res_vld_o && res_o.done_res, phase_q == PH_IDLE,
                   "sector end did not return to idle")
  `LSD_ASSERT(a_one_kind,
              res_vld_o |-> res_o.data_valid != res_o.done_res,
              "result is neither data nor done")
  `LSD_ASSERT(a_trailer_bound,
              phase_q == PH_PRE |-> trail_q <= PreSumSkip,
              "trailer count overran")

endmodule

/* src/lsd_out_stage.sv */
// result register between the core and the output channel
module lsd_out_stage import lsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      load_i,
  input  res_word_t res_i,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output logic      free_o,
  output res_word_t res_o
);

  logic      vld_q, vld_d;
  res_word_t res_q;

  assign free_o = !vld_q || out_ready_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (out_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

/* src/log_sector_deframer.sv */
// top level of the log sector deframer
// Takes one word per cycle when the output side keeps up. A word is held in
// an input register, processed combinationally by the core, and any result
// lands in an output register. A word may wait in the input register while
// the output register holds a result the receiver has not taken. The input
// stalls only while a result waits in the output register and the receiver
// is not ready. Data bytes leave two bytes late; the terminator is never sent.
// The core's combinational update allows one word per clock when not stalled.
module log_sector_deframer import lsd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [1:0]       kind_i,
  input  logic [ByteW-1:0] rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             data_valid_o,
  output logic [ByteW-1:0] out_byte_o,
  output logic             done_res_o,
  output logic [1:0]       status_o,
  output logic [LenW-1:0]  data_length_o
);

  logic      in_vld_q;
  in_word_t  in_q;
  logic      free;
  logic      step;
  logic      res_vld;
  res_word_t res;
  res_word_t res_out;

  assign step       = in_vld_q && free;
  assign in_ready_o = !in_vld_q || free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q.kind    <= kind_i;
      in_q.rx_byte <= rx_byte_i;
    end
  end

  lsd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .word_i    (in_q),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  lsd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step && res_vld),
    .res_i       (res),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (free),
    .res_o       (res_out)
  );

  assign data_valid_o  = res_out.data_valid;
  assign out_byte_o    = res_out.out_byte;
  assign done_res_o    = res_out.done_res;
  assign status_o      = res_out.status;
  assign data_length_o = res_out.data_length;

endmodule

/* verif/lsd_sector_checker.sv */
// checker that predicts and checks the results of the log sector deframer
module lsd_sector_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [1:0]          kind_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic                data_valid_i,
  input  logic [7:0]          out_byte_i,
  input  logic                done_res_i,
  input  logic [1:0]          status_i,
  input  logic [15:0]         data_length_i,
  output int                  fail_count_o,
  output int                  pending_o,
  output int                  data_seen_o,
  output int                  ok_seen_o,
  output int                  bad_seen_o,
  output int                  tmo_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lsd_pkg::*;

  phase_e          sec_phase;
  logic [7:0]      hist_old;
  logic [7:0]      hist_new;
  logic [7:0]      csum;
  logic [7:0]      sum_byte;
  logic [15:0]     rx_count;
  logic [3:0]      skip_count;
  res_word_t       sector_results_q[$];
  int              fails = 0;
  int              n_data = 0;
  int              n_ok = 0;
  int              n_bad = 0;
  int              n_tmo = 0;

  function automatic void clear_sector();
    sec_phase  = PH_IDLE;
    hist_old   = '0;
    hist_new   = '0;
    csum       = '0;
    sum_byte   = '0;
    rx_count   = '0;
    skip_count = '0;
  endfunction

  function automatic void close_sector(status_e st);
    res_word_t r;
    r = '0;
    r.done_res = 1'b1;
    r.status = st;
    r.data_length = (rx_count >= 16'd2) ? rx_count - 16'd2 : '0;
    sector_results_q.push_back(r);
    sec_phase = PH_IDLE;
  endfunction

  function automatic void deframe_word(logic [1:0] kind, logic [7:0] c);
    res_word_t r;
    case (kind)
      KIND_START: begin
        clear_sector();
        sec_phase = PH_DATA;
      end
      KIND_TIMEOUT: begin
        if (sec_phase != PH_IDLE) close_sector(STATUS_TIMEOUT);
      end
      KIND_BYTE: begin
        case (sec_phase)
          PH_DATA: begin
            if (hist_old == CharE && hist_new == CharN && c == CharD) begin
              csum = csum ^ CharE ^ CharN;
              skip_count = '0;
              sec_phase = PH_PRE;
            end else begin
              if (rx_count >= 16'd2) begin
                r = '0;
                r.data_valid = 1'b1;
                r.out_byte = hist_old;
                sector_results_q.push_back(r);
              end
              csum = csum ^ c;
              hist_old = hist_new;
              hist_new = c;
              if (rx_count != LenMax) rx_count = rx_count + 16'd1;
            end
          end
          PH_PRE: begin
            if (skip_count < PreSumSkip) begin
              skip_count = skip_count + 4'd1;
            end else begin
              sum_byte = c;
              skip_count = '0;
              sec_phase = PH_POST;
              if (PostSumSkip == '0) close_sector(csum == sum_byte ? STATUS_OK : STATUS_BAD);
            end
          end
          PH_POST: begin
            skip_count = skip_count + 4'd1;
            if (skip_count >= PostSumSkip)
              close_sector(csum == sum_byte ? STATUS_OK : STATUS_BAD);
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      fails++;
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_word_t want;
    if (!rst_ni) begin
      clear_sector();
      sector_results_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (sector_results_q.size() == 0) begin
          fails++;
          $error("result with nothing expected: data_valid %0d out_byte %0d done_res %0d",
                 data_valid_i, out_byte_i, done_res_i);
        end else begin
          want = sector_results_q.pop_front();
          check_field("data_valid", want.data_valid, data_valid_i);
          check_field("out_byte", want.out_byte, out_byte_i);
          check_field("done_res", want.done_res, done_res_i);
          check_field("status", want.status, status_i);
          check_field("data_length", want.data_length, data_length_i);
          if (want.data_valid) n_data++;
          else if (want.status == STATUS_OK) n_ok++;
          else if (want.status == STATUS_BAD) n_bad++;
          else n_tmo++;
        end
      end
      if (in_valid_i && in_ready_i) deframe_word(kind_i, rx_byte_i);
    end
    fail_count_o <= fails;
    pending_o <= sector_results_q.size();
    data_seen_o <= n_data;
    ok_seen_o <= n_ok;
    bad_seen_o <= n_bad;
    tmo_seen_o <= n_tmo;
  end

endmodule

/* verif/tb_log_sector_deframer.sv */
// testbench top: sends sectors into the log sector deframer and gives the verdict
module tb_log_sector_deframer;
  timeunit 1ns;
  timeprecision 1ps;
  import lsd_pkg::*;

  localparam logic [1:0] KindUnused = 2'd3;
  localparam int RandomWords = 1100;
  localparam int CycleLimit = 600000;
  localparam int DrainCycles = 12;
  localparam int HoldCycles = 400;
  localparam int HoldAfter = 150;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KIND_START;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        data_valid_o;
  logic [7:0]  out_byte_o;
  logic        done_res_o;
  logic [1:0]  status_o;
  logic [15:0] data_length_o;

  int fail_count;
  int pending;
  int data_seen;
  int ok_seen;
  int bad_seen;
  int tmo_seen;

  int cycle_count = 0;
  int sector_words = 0;
  int tx_run_left = 0;
  bit tx_calm = 1'b0;
  int rx_run_left = 0;
  bit rx_calm = 1'b0;

  log_sector_deframer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_valid_o  (data_valid_o),
    .out_byte_o    (out_byte_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o),
    .data_length_o (data_length_o)
  );

  lsd_sector_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .kind_i        (kind_i),
    .rx_byte_i     (rx_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .data_valid_i  (data_valid_o),
    .out_byte_i    (out_byte_o),
    .done_res_i    (done_res_o),
    .status_i      (status_o),
    .data_length_i (data_length_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .data_seen_o   (data_seen),
    .ok_seen_o     (ok_seen),
    .bad_seen_o    (bad_seen),
    .tmo_seen_o    (tmo_seen)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("run stopped after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // stretches of back-to-back words or of random gaps, each stretch picked at random
  task automatic draw_gap(inout int run_left, inout bit calm, output int gap);
    if (run_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      run_left = $urandom_range(20, 80);
    end
    run_left--;
    gap = calm ? 0 : $urandom_range(0, 14);
  endtask

  task automatic send_word(input logic [1:0] kind, input logic [7:0] b);
    int gap;
    draw_gap(tx_run_left, tx_calm, gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    kind_i <= kind;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic play_sector(input int n_data, input bit bad_sum, input int cut_at,
                             input bit cut_timeout);
    in_word_t   words[$];
    logic [7:0] sum;
    logic [7:0] h_old;
    logic [7:0] h_new;
    logic [7:0] b;
    int         stop;
    sum = '0;
    h_old = '0;
    h_new = '0;
    words.push_back({KIND_START, 8'($urandom)});
    for (int i = 0; i < n_data; i++) begin
      b = 8'($urandom);
      // keep the terminator out of the data
      if (h_old == CharE && h_new == CharN && b == CharD) b = ~CharD;
      if ($urandom_range(0, 29) == 0) words.push_back({KindUnused, 8'($urandom)});
      words.push_back({KIND_BYTE, b});
      sum = sum ^ b;
      h_old = h_new;
      h_new = b;
    end
    words.push_back({KIND_BYTE, CharE});
    words.push_back({KIND_BYTE, CharN});
    words.push_back({KIND_BYTE, CharD});
    for (int i = 0; i < PreSumSkip; i++) words.push_back({KIND_BYTE, 8'($urandom)});
    if (bad_sum) sum = sum ^ 8'($urandom_range(1, 255));
    words.push_back({KIND_BYTE, sum});
    for (int i = 0; i < PostSumSkip; i++) words.push_back({KIND_BYTE, 8'($urandom)});
    stop = (cut_at < 0 || cut_at >= words.size()) ? words.size() : cut_at;
    for (int i = 0; i < stop; i++) send_word(words[i].kind, words[i].rx_byte);
    sector_words += stop;
    if (stop < words.size() && cut_timeout) begin
      send_word(KIND_TIMEOUT, 8'($urandom));
      sector_words++;
    end
  endtask

  initial begin
    int n;
    int pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle noise, restart over an open terminator, short sectors
    send_word(KIND_BYTE, 8'hAA);
    send_word(KIND_TIMEOUT, 8'h55);
    send_word(KindUnused, 8'hFF);
    send_word(KIND_START, 8'h00);
    send_word(KIND_BYTE, CharE);
    send_word(KIND_BYTE, CharN);
    send_word(KIND_START, 8'hFF);
    send_word(KIND_BYTE, CharD);
    send_word(KindUnused, 8'h00);
    send_word(KIND_TIMEOUT, 8'hFF);
    send_word(KIND_START, 8'h5A);
    send_word(KIND_BYTE, CharN);
    send_word(KIND_BYTE, CharD);
    send_word(KIND_BYTE, 8'hFF);
    send_word(KIND_BYTE, 8'h00);
    send_word(KIND_TIMEOUT, 8'h00);

    while (sector_words < RandomWords) begin
      n = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 120) : $urandom_range(0, 16);
      pick = $urandom_range(0, 99);
      if (pick < 65) play_sector(n, $urandom_range(0, 3) == 0, -1, 1'b0);
      else play_sector(n, 1'b0, $urandom_range(1, n + 19), pick < 85);
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          case ($urandom_range(0, 2))
            0: send_word(KIND_BYTE, 8'($urandom));
            1: send_word(KIND_TIMEOUT, 8'($urandom));
            default: send_word(KindUnused, 8'($urandom));
          endcase
        end
      end
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("checked %0d data bytes and %0d sector ends (%0d sum ok, %0d sum bad, %0d timeout)",
             data_seen, ok_seen + bad_seen + tmo_seen, ok_seen, bad_seen, tmo_seen);
    $display("%0d words sent in whole, cut and restarted sectors, with one long output stall",
             sector_words);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int gap;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      draw_gap(rx_run_left, rx_calm, gap);
      // one long hold-off so the block backs up into its input
      if (!held && taken >= HoldAfter) begin
        gap = HoldCycles;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

endmodule

/* sim.f */
+incdir+src
src/lsd_pkg.sv
src/lsd_core.sv
src/lsd_out_stage.sv
src/log_sector_deframer.sv
verif/lsd_sector_checker.sv
verif/tb_log_sector_deframer.sv
